// ===== rtl/bsc_pkg.sv =====
// ============================================================================
// bsc_pkg: shared types and constants of the safety checker
// Default sizes, request codes, cell operations, cell control bundle and FSM states.
// ============================================================================
package bsc_pkg;

    localparam int BSC_MAX_PROCS = 16;
    localparam int BSC_MAX_RES   = 8;
    localparam int BSC_UNIT_BITS = 8;

    localparam logic [15:0] FREE_MAX = 16'hFFFF;

    // Request codes carried by func
    typedef enum logic [2:0] {
        FN_WR_ALLOC = 3'd0,
        FN_WR_MAX   = 3'd1,
        FN_WR_FREE  = 3'd2,
        FN_SET_CNT  = 3'd3,
        FN_CHECK    = 3'd4,
        FN_RECOVER  = 3'd5
    } func_t;

    // Operation applied to every cell of the row in the same cycle
    typedef enum logic [2:0] {
        CELL_HOLD     = 3'd0,
        CELL_WR_ALLOC = 3'd1,
        CELL_WR_MAX   = 3'd2,
        CELL_CLR_DONE = 3'd3,
        CELL_ROTATE   = 3'd4,
        CELL_SHIFT    = 3'd5
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     sel;   // write target, or take neighbor on shift
        logic     zero;  // clear masked columns on shift
    } cell_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_INIT,
        ST_CHK_START,
        ST_CHK_SCAN,
        ST_FINISH,
        ST_EMIT,
        ST_REC_SCAN,
        ST_REC_APPLY
    } state_t;

endpackage

// ===== rtl/bsc_cell.sv =====
// ============================================================================
// bsc_cell: one process row of the checker
// Holds the allocation row, the max-claim row and the finished flag; loads
// from its neighbor on rotate and on the recovery shift.
// ============================================================================
module bsc_cell
    import bsc_pkg::*;
#(
    parameter int MAX_RES   = BSC_MAX_RES,
    parameter int UNIT_BITS = BSC_UNIT_BITS,
    parameter int RW        = (MAX_RES > 1) ? $clog2(MAX_RES) : 1
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cell_ctl_t                          ctl,
    input  logic [RW-1:0]                      wr_col,
    input  logic [UNIT_BITS-1:0]               wr_data,
    input  logic [MAX_RES-1:0]                 col_mask,
    input  logic [MAX_RES-1:0][UNIT_BITS-1:0]  nb_alloc,
    input  logic [MAX_RES-1:0][UNIT_BITS-1:0]  nb_max,
    input  logic                               nb_done,
    output logic [MAX_RES-1:0][UNIT_BITS-1:0]  alloc,
    output logic [MAX_RES-1:0][UNIT_BITS-1:0]  max_claim,
    output logic                               done
);

    logic [MAX_RES-1:0][UNIT_BITS-1:0] alloc_reg, alloc_next;
    logic [MAX_RES-1:0][UNIT_BITS-1:0] max_reg, max_next;
    logic                              done_reg, done_next;

    // Select next row contents
    always_comb
    begin
        alloc_next = alloc_reg;
        max_next   = max_reg;
        done_next  = done_reg;
        unique case (ctl.op)
            CELL_HOLD:
            begin
            end
            CELL_WR_ALLOC:
            begin
                if (ctl.sel)
                begin
                    alloc_next[wr_col] = wr_data;
                end
            end
            CELL_WR_MAX:
            begin
                if (ctl.sel)
                begin
                    max_next[wr_col] = wr_data;
                end
            end
            CELL_CLR_DONE:
            begin
                done_next = 1'b0;
            end
            CELL_ROTATE:
            begin
                alloc_next = nb_alloc;
                max_next   = nb_max;
                done_next  = nb_done;
            end
            CELL_SHIFT:
            begin
                for (int j = 0; j < MAX_RES; j++)
                begin
                    if (col_mask[j] && ctl.sel)
                    begin
                        alloc_next[j] = nb_alloc[j];
                        max_next[j]   = nb_max[j];
                    end
                    else if (col_mask[j] && ctl.zero)
                    begin
                        alloc_next[j] = '0;
                        max_next[j]   = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold row state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_reg <= '0;
            max_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            alloc_reg <= alloc_next;
            max_reg   <= max_next;
            done_reg  <= done_next;
        end
    end

    assign alloc     = alloc_reg;
    assign max_claim = max_reg;
    assign done      = done_reg;

endmodule

// ===== rtl/banker_safety_check_and_recovery.sv =====
// ============================================================================
// banker_safety_check_and_recovery: resource safety checker with recovery
// Table loading, safety check over a rotating row of process cells, and
// removal of the heaviest process after an unsafe check.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries func, proc_index, res_index and
//   value. Table writes and the process count give no result. A check or
//   recover item produces one or more result transfers on the output
//   channel (out_valid/out_ready); last marks the final one.
//   The configuration channel (cfg_valid/cfg_ready) writes resource_count and
//   is always ready; write it only while the block is idle.
//   A check rotates the process cells once per pass, evaluating the row at
//   the head cell against the work vector each cycle. Recovery first scans
//   for the victim, then shifts it out of the row and runs the check again.
//   in_ready is high only while idle. A stalled receiver holds the output
//   register, and the result sequence waits without loss.
//   Reset clears all tables, the process count and the safe flag, and sets
//   resource_count to 3.
// ============================================================================
module banker_safety_check_and_recovery
    import bsc_pkg::*;
#(
    parameter int MAX_PROCS = BSC_MAX_PROCS,
    parameter int MAX_RES   = BSC_MAX_RES,
    parameter int UNIT_BITS = BSC_UNIT_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  resource_count,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [3:0]  proc_index,
    input  logic [2:0]  res_index,
    input  logic [15:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        safe,
    output logic        has_entry,
    output logic [3:0]  seq_process,
    output logic [4:0]  passes,
    output logic        victim_valid,
    output logic [3:0]  victim,
    output logic        last
);

    localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW    = $clog2(MAX_PROCS + 1);
    localparam int RW    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int TW    = UNIT_BITS + $clog2(MAX_RES + 1);
    localparam logic [16:0] UNIT_MAX = 17'((1 << UNIT_BITS) - 1);

    state_t state_reg, state_next;

    logic [3:0]             rc_reg;
    logic [CW-1:0]          pcount_reg;
    logic                   last_safe_reg;
    logic [MAX_RES-1:0][15:0] free_reg;
    logic [MAX_RES-1:0][15:0] work_reg;
    logic [PW-1:0]          idx_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          passes_reg;
    logic                   found_reg;
    logic                   single_reg;
    logic [CW-1:0]          k_reg;
    logic                   vv_reg;
    logic [PW-1:0]          victim_reg;
    logic                   any_reg;
    logic [TW-1:0]          best_reg;
    logic [MAX_RES-1:0][UNIT_BITS-1:0] vic_alloc_reg;
    logic [PW-1:0]          order_reg [MAX_PROCS];

    logic                   out_valid_reg;
    logic                   safe_reg, has_reg, last_reg, ovv_reg;
    logic [3:0]             seq_reg, ovic_reg;
    logic [4:0]             opass_reg;

    // Cell row wiring
    cell_ctl_t                         ctl [MAX_PROCS];
    logic [MAX_RES-1:0][UNIT_BITS-1:0] c_alloc [MAX_PROCS];
    logic [MAX_RES-1:0][UNIT_BITS-1:0] c_max [MAX_PROCS];
    logic                              c_done [MAX_PROCS];

    logic                   in_fire;
    func_t                  fn;
    logic [MAX_RES-1:0]     col_mask;
    logic [UNIT_BITS-1:0]   unit_val;
    logic [RW-1:0]          wr_col;
    logic                   col_ok;
    logic                   head_in_range;
    logic                   fits;
    logic                   grant;
    logic                   head_done_in;
    logic [MAX_RES-1:0][15:0] work_sum;
    logic [TW-1:0]          total;
    logic                   rec_better;
    logic                   scan_end;
    logic                   out_load;
    logic                   emit_end;

    assign in_fire   = in_valid && in_ready;
    assign fn        = func_t'(func);
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign unit_val  = (17'(value) > UNIT_MAX) ? UNIT_MAX[UNIT_BITS-1:0]
                                                : value[UNIT_BITS-1:0];
    assign wr_col    = RW'(res_index);
    assign col_ok    = (32'(res_index) < MAX_RES);
    assign scan_end  = (32'(idx_reg) == MAX_PROCS - 1);
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign emit_end  = single_reg || (k_reg == pcount_reg - CW'(1));

    // Active resource columns
    always_comb
    begin
        for (int j = 0; j < MAX_RES; j++)
        begin
            col_mask[j] = (32'(rc_reg) > j);
        end
    end

    // Evaluate the head row against the work vector
    always_comb
    begin
        logic [UNIT_BITS-1:0] need;
        logic [16:0]          s;
        fits  = 1'b1;
        total = '0;
        for (int j = 0; j < MAX_RES; j++)
        begin
            need = (c_max[0][j] > c_alloc[0][j]) ? c_max[0][j] - c_alloc[0][j] : '0;
            if (col_mask[j] && (16'(need) > work_reg[j]))
            begin
                fits = 1'b0;
            end
            s = 17'(work_reg[j]) + 17'(c_alloc[0][j]);
            work_sum[j] = (s > 17'(FREE_MAX)) ? FREE_MAX : s[15:0];
            if (col_mask[j])
            begin
                total = total + TW'(c_alloc[0][j]);
            end
        end
    end

    assign head_in_range = (CW'(idx_reg) < pcount_reg);
    assign grant         = (state_reg == ST_CHK_SCAN) && head_in_range
                           && !c_done[0] && fits;
    assign head_done_in  = c_done[0] || grant;
    assign rec_better    = (state_reg == ST_REC_SCAN) && head_in_range
                           && (!any_reg || (total > best_reg));

    // Cell row
    for (genvar i = 0; i < MAX_PROCS; i++)
    begin : g_cell
        always_comb
        begin
            ctl[i].op   = CELL_HOLD;
            ctl[i].sel  = 1'b0;
            ctl[i].zero = 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    ctl[i].sel = (32'(proc_index) == i) && col_ok;
                    if (in_fire && (fn == FN_WR_ALLOC))
                    begin
                        ctl[i].op = CELL_WR_ALLOC;
                    end
                    else if (in_fire && (fn == FN_WR_MAX))
                    begin
                        ctl[i].op = CELL_WR_MAX;
                    end
                end
                ST_CHK_INIT:
                begin
                    ctl[i].op = CELL_CLR_DONE;
                end
                ST_CHK_SCAN, ST_REC_SCAN:
                begin
                    ctl[i].op = CELL_ROTATE;
                end
                ST_REC_APPLY:
                begin
                    ctl[i].op   = CELL_SHIFT;
                    ctl[i].sel  = (CW'(i) >= CW'(victim_reg))
                                  && (CW'(i) + CW'(1) < pcount_reg);
                    ctl[i].zero = (CW'(i) == CW'(victim_reg))
                                  && (CW'(i) + CW'(1) == pcount_reg);
                end
                default:
                begin
                end
            endcase
        end

        if (i == MAX_PROCS - 1)
        begin : g_tail
            bsc_cell #(.MAX_RES(MAX_RES), .UNIT_BITS(UNIT_BITS), .RW(RW)) u_cell (
                .clk(clk), .rst_n(rst_n), .ctl(ctl[i]), .wr_col(wr_col),
                .wr_data(unit_val), .col_mask(col_mask),
                .nb_alloc(c_alloc[0]), .nb_max(c_max[0]), .nb_done(head_done_in),
                .alloc(c_alloc[i]), .max_claim(c_max[i]), .done(c_done[i])
            );
        end
        else
        begin : g_body
            bsc_cell #(.MAX_RES(MAX_RES), .UNIT_BITS(UNIT_BITS), .RW(RW)) u_cell (
                .clk(clk), .rst_n(rst_n), .ctl(ctl[i]), .wr_col(wr_col),
                .wr_data(unit_val), .col_mask(col_mask),
                .nb_alloc(c_alloc[i+1]), .nb_max(c_max[i+1]), .nb_done(c_done[i+1]),
                .alloc(c_alloc[i]), .max_claim(c_max[i]), .done(c_done[i])
            );
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (fn == FN_CHECK))
                begin
                    state_next = ST_CHK_INIT;
                end
                else if (in_fire && (fn == FN_RECOVER))
                begin
                    state_next = (last_safe_reg || (pcount_reg == '0)) ? ST_EMIT
                                                                      : ST_REC_SCAN;
                end
            end
            ST_CHK_INIT:
            begin
                state_next = ST_CHK_START;
            end
            ST_CHK_START:
            begin
                state_next = (count_reg == pcount_reg) ? ST_FINISH : ST_CHK_SCAN;
            end
            ST_CHK_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = (found_reg || grant) ? ST_CHK_START : ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load && emit_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REC_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_REC_APPLY;
                end
            end
            ST_REC_APPLY:
            begin
                state_next = ST_CHK_INIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg        <= 4'd3;
            pcount_reg    <= '0;
            last_safe_reg <= 1'b0;
            free_reg      <= '0;
            work_reg      <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            passes_reg    <= '0;
            found_reg     <= 1'b0;
            single_reg    <= 1'b0;
            k_reg         <= '0;
            vv_reg        <= 1'b0;
            victim_reg    <= '0;
            any_reg       <= 1'b0;
            best_reg      <= '0;
            vic_alloc_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                rc_reg <= resource_count;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    vv_reg     <= 1'b0;
                    victim_reg <= '0;
                    passes_reg <= '0;
                    single_reg <= 1'b1;
                    k_reg      <= '0;
                    idx_reg    <= '0;
                    any_reg    <= 1'b0;
                    if (in_fire && (fn == FN_WR_FREE) && col_ok)
                    begin
                        free_reg[wr_col] <= value;
                    end
                    if (in_fire && (fn == FN_SET_CNT))
                    begin
                        pcount_reg <= (32'(value) > MAX_PROCS) ? CW'(MAX_PROCS)
                                                              : CW'(value);
                    end
                end
                ST_CHK_INIT:
                begin
                    work_reg   <= free_reg;
                    count_reg  <= '0;
                    passes_reg <= '0;
                end
                ST_CHK_START:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    if (count_reg != pcount_reg)
                    begin
                        passes_reg <= passes_reg + CW'(1);
                    end
                end
                ST_CHK_SCAN:
                begin
                    idx_reg <= scan_end ? '0 : idx_reg + PW'(1);
                    if (grant)
                    begin
                        for (int j = 0; j < MAX_RES; j++)
                        begin
                            if (col_mask[j])
                            begin
                                work_reg[j] <= work_sum[j];
                            end
                        end
                        count_reg <= count_reg + CW'(1);
                        found_reg <= 1'b1;
                    end
                end
                ST_FINISH:
                begin
                    last_safe_reg <= (count_reg == pcount_reg);
                    single_reg    <= (count_reg != pcount_reg) || (pcount_reg == '0);
                    k_reg         <= '0;
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        k_reg <= k_reg + CW'(1);
                    end
                end
                ST_REC_SCAN:
                begin
                    idx_reg <= scan_end ? '0 : idx_reg + PW'(1);
                    if (rec_better)
                    begin
                        any_reg       <= 1'b1;
                        best_reg      <= total;
                        victim_reg    <= idx_reg;
                        vic_alloc_reg <= c_alloc[0];
                    end
                end
                ST_REC_APPLY:
                begin
                    for (int j = 0; j < MAX_RES; j++)
                    begin
                        if (col_mask[j])
                        begin
                            free_reg[j] <= ((17'(free_reg[j]) + 17'(vic_alloc_reg[j]))
                                            > 17'(FREE_MAX)) ? FREE_MAX
                                           : free_reg[j] + 16'(vic_alloc_reg[j]);
                        end
                    end
                    pcount_reg <= pcount_reg - CW'(1);
                    vv_reg     <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Record the safe order
    always_ff @(posedge clk)
    begin
        if (grant)
        begin
            order_reg[count_reg[PW-1:0]] <= idx_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            safe_reg  <= last_safe_reg;
            has_reg   <= !single_reg;
            seq_reg   <= single_reg ? 4'd0 : 4'(order_reg[k_reg[PW-1:0]]);
            opass_reg <= 5'(passes_reg);
            ovv_reg   <= vv_reg;
            ovic_reg  <= 4'(victim_reg);
            last_reg  <= emit_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign safe         = safe_reg;
    assign has_entry    = has_reg;
    assign seq_process  = seq_reg;
    assign passes       = opass_reg;
    assign victim_valid = ovv_reg;
    assign victim       = ovic_reg;
    assign last         = last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHK_SCAN) |-> (count_reg <= pcount_reg))
        else $error("granted count exceeds process count");

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHK_SCAN && scan_end) |=>
        (state_reg == ST_CHK_START || state_reg == ST_FINISH))
        else $error("pass did not close after a full rotation");

    a_remove_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REC_APPLY) |=> (pcount_reg == $past(pcount_reg) - CW'(1)))
        else $error("recovery did not remove exactly one process");

    a_entry_safe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && has_entry) |-> safe)
        else $error("order entry reported for an unsafe check");
`endif

endmodule
